[rtl/urxpp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urxpp_pkg
// Shared codes, widths and types of the ping-pong receive buffer.
// ---------------------------------------------------------------------------
package urxpp_pkg;

    localparam int HALF_DEPTH_DEF = 256;
    // Wide enough for a slot address at the largest half depth (2 * 4096).
    localparam int CALC_W         = 13;

    localparam int CHAR_W  = 9;
    localparam int COUNT_W = 9;
    localparam int ERR_W   = 4;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Command codes carried on s_tuser
    localparam logic [CMD_W-1:0] CMD_CHAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_IDLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd3;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_NINE_BIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE = 2'd2;

    localparam logic [COUNT_W-1:0] HALF_SIZE_RST = 9'd256;

    localparam logic [CHAR_W-1:0] MASK_9B = 9'h1FF;
    localparam logic [CHAR_W-1:0] MASK_8B = 9'h0FF;
    localparam logic [CHAR_W-1:0] MASK_7B = 9'h07F;

    // Result fields known at accept time; read_char joins from the store.
    typedef struct packed {
        logic               handover;
        logic               handover_half;
        logic [COUNT_W-1:0] handover_count;
        logic               read_valid;
        logic [COUNT_W-1:0] ready_left;
        logic [ERR_W-1:0]   error_word;
    } result_t;

endpackage

[rtl/urxpp_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urxpp_store
// Character store: one write port, one read port, registered read data.
// A read and a write to the same slot in one cycle returns the old data.
// ---------------------------------------------------------------------------
module urxpp_store
    import urxpp_pkg::*;
#(
    parameter int DEPTH = 2 * HALF_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [CHAR_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [CHAR_W-1:0]        rd_data
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/uart_rx_pingpong_buffer.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uart_rx_pingpong_buffer
// Ping-pong receive buffer: masks characters into the filling half, hands a
// half over when full or on idle, pops characters from the handed-over half
// and keeps a sticky error word.
//
//   channel | signals                      | beat contents (low bit up)
//   s_      | s_tvalid s_tready s_tuser    | tuser: cmd; tdata: rx_char, err_bits
//           | s_tdata                      |
//   m_      | m_tvalid m_tready m_tuser    | tuser: handover, read_valid; tdata:
//           | m_tdata                      | handover_half, handover_count,
//           |                              | read_char, ready_left, error_word
//   cfg_    | cfg_valid cfg_ready          | index: register; data: value
//           | cfg_index cfg_data           |
//
// One beat per cycle in and out while m_ does not stall; each beat passes the store
// read stage, then the output register, before its result appears on m_.
// The single read port of the character store, at most one access per beat, sets the
// rate. Reset clears all counters and flags; the store itself is not cleared.
// A stall on m_ holds the output register and the store read stage; s_tready
// drops only when both are occupied and m_tready is low.
// ---------------------------------------------------------------------------
module uart_rx_pingpong_buffer
    import urxpp_pkg::*;
#(
    parameter int HALF_DEPTH = HALF_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CMD_W-1:0]      s_tuser,    // cmd
    input  logic [15:0]           s_tdata,    // rx_char[8:0], err_bits[12:9], zero fill

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [1:0]            m_tuser,    // handover[0], read_valid[1]
    output logic [31:0]           m_tdata,    // handover_half[0], handover_count[9:1],
                                              // read_char[18:10], ready_left[27:19],
                                              // error_word[31:28]

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = 2 * HALF_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CALC_W-1:0] HALF_DEPTH_C = CALC_W'(HALF_DEPTH);

    // Configuration
    logic               nine_bit_reg;
    logic               parity_reg;
    logic [COUNT_W-1:0] half_size_reg;

    // Buffer state
    logic               fill_half_reg,   fill_half_next;
    logic [COUNT_W-1:0] fill_count_reg,  fill_count_next;
    logic               ready_half_reg,  ready_half_next;
    logic [COUNT_W-1:0] ready_count_reg, ready_count_next;
    logic [COUNT_W-1:0] read_offset_reg, read_offset_next;
    logic [ERR_W-1:0]   sticky_reg,      sticky_next;

    // Store read stage and output register
    logic               s1_valid_reg;
    result_t            s1_res_reg;
    result_t            res_next;
    logic               out_valid_reg;
    logic [1:0]         out_user_reg;
    logic [31:0]        out_data_reg;

    logic               s1_advance;
    logic               s_accept;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [CHAR_W-1:0]  wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [CHAR_W-1:0]  rd_data;

    logic [CMD_W-1:0]   cmd;
    logic [CHAR_W-1:0]  rx_char;
    logic [ERR_W-1:0]   err_bits;

    assign cmd      = s_tuser;
    assign rx_char  = s_tdata[8:0];
    assign err_bits = s_tdata[12:9];

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    function automatic logic [AW-1:0] slot_addr(input logic half, input logic [COUNT_W-1:0] off);
        logic [CALC_W-1:0] sum;
        sum = (half ? HALF_DEPTH_C : CALC_W'(0)) + CALC_W'(off);
        return sum[AW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nine_bit_reg  <= 1'b0;
            parity_reg    <= 1'b0;
            half_size_reg <= HALF_SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NINE_BIT:  nine_bit_reg  <= cfg_data[0];
                REG_PARITY:    parity_reg    <= cfg_data[0];
                REG_HALF_SIZE: half_size_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        logic [CHAR_W-1:0]  mask;
        logic [CALC_W-1:0]  eff_wide;
        logic [COUNT_W-1:0] eff_size;
        logic [COUNT_W-1:0] fc_inc;
        logic               do_handover;
        logic [COUNT_W-1:0] ho_count;

        case ({nine_bit_reg, parity_reg})
            2'b00:   mask = MASK_8B;
            2'b01:   mask = MASK_7B;
            2'b10:   mask = MASK_9B;
            default: mask = MASK_8B;
        endcase

        // Clamp the half size to 1..HALF_DEPTH
        if (half_size_reg == '0)
            eff_wide = CALC_W'(1);
        else if (CALC_W'(half_size_reg) > HALF_DEPTH_C)
            eff_wide = HALF_DEPTH_C;
        else
            eff_wide = CALC_W'(half_size_reg);
        eff_size = eff_wide[COUNT_W-1:0];

        fill_half_next   = fill_half_reg;
        fill_count_next  = fill_count_reg;
        ready_half_next  = ready_half_reg;
        ready_count_next = ready_count_reg;
        read_offset_next = read_offset_reg;
        sticky_next      = sticky_reg;

        wr_en   = 1'b0;
        wr_addr = slot_addr(fill_half_reg, fill_count_reg);
        wr_data = rx_char & mask;
        rd_en   = 1'b0;
        rd_addr = slot_addr(ready_half_reg, read_offset_reg);

        fc_inc      = fill_count_reg;
        do_handover = 1'b0;
        ho_count    = '0;
        res_next    = '0;

        if (s_accept)
        begin
            case (cmd)
                CMD_CHAR:
                begin
                    if (CALC_W'(fill_count_reg) < HALF_DEPTH_C)
                    begin
                        wr_en  = 1'b1;
                        fc_inc = fill_count_reg + COUNT_W'(1);
                    end
                    fill_count_next = fc_inc;
                    if (fc_inc >= eff_size)
                    begin
                        do_handover = 1'b1;
                        ho_count    = fc_inc;
                    end
                end
                CMD_IDLE:
                begin
                    if (fill_count_reg != '0)
                    begin
                        do_handover = 1'b1;
                        ho_count    = fill_count_reg;
                    end
                end
                CMD_ERR:
                begin
                    sticky_next = sticky_reg | err_bits;
                end
                default:
                begin
                    // Pop one slot and clear it behind the read
                    if (ready_count_reg != '0)
                    begin
                        rd_en   = 1'b1;
                        wr_en   = 1'b1;
                        wr_addr = rd_addr;
                        wr_data = '0;
                        read_offset_next = read_offset_reg + COUNT_W'(1);
                        ready_count_next = ready_count_reg - COUNT_W'(1);
                        res_next.read_valid = 1'b1;
                    end
                end
            endcase

            if (do_handover)
            begin
                ready_half_next  = fill_half_reg;
                ready_count_next = ho_count;
                read_offset_next = '0;
                fill_half_next   = !fill_half_reg;
                fill_count_next  = '0;
                res_next.handover       = 1'b1;
                res_next.handover_half  = fill_half_reg;
                res_next.handover_count = ho_count;
            end

            res_next.ready_left = ready_count_next;
            res_next.error_word = sticky_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_half_reg   <= 1'b0;
            fill_count_reg  <= '0;
            ready_half_reg  <= 1'b0;
            ready_count_reg <= '0;
            read_offset_reg <= '0;
            sticky_reg      <= '0;
        end
        else
        begin
            fill_half_reg   <= fill_half_next;
            fill_count_reg  <= fill_count_next;
            ready_half_reg  <= ready_half_next;
            ready_count_reg <= ready_count_next;
            read_offset_reg <= read_offset_next;
            sticky_reg      <= sticky_next;
        end
    end

    urxpp_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Store read stage: hold while the output register is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_user_reg <= {s1_res_reg.read_valid, s1_res_reg.handover};
            out_data_reg <= {s1_res_reg.error_word,
                             s1_res_reg.ready_left,
                             (s1_res_reg.read_valid ? rd_data : CHAR_W'(0)),
                             s1_res_reg.handover_count,
                             s1_res_reg.handover_half};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CALC_W'(fill_count_reg) < HALF_DEPTH_C)
        else $error("fill count reached the half depth");

    a_read_window: assert property (@(posedge clk) disable iff (!rst_n)
        (CALC_W'(read_offset_reg) + CALC_W'(ready_count_reg)) <= HALF_DEPTH_C)
        else $error("read window runs past the handed-over half");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |-> !s_accept)
        else $error("beat accepted while the read stage is blocked");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("read stage dropped a stalled beat");

    a_handover_resets_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && res_next.handover) |=> (fill_count_reg == '0 && read_offset_reg == '0))
        else $error("handover left fill count or read offset set");

endmodule
